### rtl/fdwf_pkg.sv
package fdwf_pkg;

  localparam int unsigned WINDOW_SIZE_DEF = 32;
  localparam int unsigned QUEUE_DEPTH_DEF = 4;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned CNT_W   = 12;
  localparam int unsigned FW_W    = 13;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned SUM_W   = 32;
  localparam int unsigned FORCE_W = 24;
  localparam int unsigned PROD_W  = SUM_W + GAIN_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [PIX_W-1:0] NOISE_FLOOR = 8'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEFT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_TOP  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FORCE_GAIN  = 2'd3;

  localparam logic [FW_W-1:0]   FRAME_WIDTH_RST = 13'd640;
  localparam logic [CNT_W-1:0]  WINDOW_LEFT_RST = 12'd0;
  localparam logic [CNT_W-1:0]  WINDOW_TOP_RST  = 12'd0;
  localparam logic [GAIN_W-1:0] FORCE_GAIN_RST  = 16'd2570;

  // Classified pixel as it leaves the front part
  typedef struct packed {
    logic [PIX_W-1:0] diff;
    logic [CNT_W-1:0] mcol;
    logic [CNT_W-1:0] row;
    logic             in_win;
    logic             eof;
  } fdwf_pix_t;

  localparam int unsigned PIX_T_W = $bits(fdwf_pix_t);

  // Q0.16 product: floor shift by 16, then clamp to signed 24 bits
  function automatic logic [FORCE_W-1:0] sat_force(input logic [PROD_W-1:0] p);
    logic [SUM_W-1:0] q;
    logic [FORCE_W-1:0] r;
    q = p[PROD_W-1:GAIN_W];
    if (q[SUM_W-1:FORCE_W-1] == '0 || q[SUM_W-1:FORCE_W-1] == '1) begin
      r = q[FORCE_W-1:0];
    end else if (q[SUM_W-1]) begin
      r = {1'b1, {(FORCE_W-1){1'b0}}};
    end else begin
      r = {1'b0, {(FORCE_W-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

### rtl/fdwf_front.sv
module fdwf_front #(
  parameter int unsigned WINDOW_SIZE = fdwf_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned DW          = $clog2(WINDOW_SIZE) + 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [fdwf_pkg::PIX_W-1:0]  prev_pixel_i,
  input  logic [fdwf_pkg::PIX_W-1:0]  cur_pixel_i,
  input  logic                        end_of_line_i,
  input  logic                        end_of_frame_i,
  input  logic [fdwf_pkg::FW_W-1:0]   frame_width_i,
  input  logic [fdwf_pkg::CNT_W-1:0]  window_left_i,
  input  logic [fdwf_pkg::CNT_W-1:0]  window_top_i,
  input  logic                        q_full_i,
  output logic                        q_push_o,
  output fdwf_pkg::fdwf_pix_t         q_pix_o,
  output logic signed [DW-1:0]        q_dx_o,
  output logic signed [DW-1:0]        q_dy_o
);
  import fdwf_pkg::*;

  localparam logic [DW-1:0]   HALF = DW'(WINDOW_SIZE / 2);
  localparam logic [FW_W-1:0] WS   = FW_W'(WINDOW_SIZE);

  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  logic [PIX_W-1:0] absd;
  logic [PIX_W-1:0] diff;
  logic [FW_W:0]    m;
  logic             x_in, y_in;
  logic [DW-1:0]    offx, offy;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;

  always_comb begin
    absd = (cur_pixel_i >= prev_pixel_i) ? cur_pixel_i - prev_pixel_i
                                         : prev_pixel_i - cur_pixel_i;
    diff = (absd > NOISE_FLOOR) ? absd - NOISE_FLOOR : '0;

    // Top bit set means the column lies beyond the frame width
    m = {1'b0, frame_width_i} - (FW_W+1)'(1) - {2'b00, col_q};

    x_in = !m[FW_W] && (m[FW_W-1:0] >= {1'b0, window_left_i})
           && (m[FW_W-1:0] < ({1'b0, window_left_i} + WS));
    y_in = ({1'b0, row_q} >= {1'b0, window_top_i})
           && ({1'b0, row_q} < ({1'b0, window_top_i} + WS));

    offx = m[DW-1:0] - window_left_i[DW-1:0];
    offy = row_q[DW-1:0] - window_top_i[DW-1:0];
  end

  always_comb begin
    q_pix_o.diff   = diff;
    q_pix_o.mcol   = m[CNT_W-1:0];
    q_pix_o.row    = row_q;
    q_pix_o.in_win = x_in && y_in;
    q_pix_o.eof    = end_of_frame_i;
    q_dx_o         = $signed(HALF - offx);
    q_dy_o         = $signed(HALF - offy);
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (q_push_o) begin
      priority if (end_of_frame_i) begin
        col_d = '0;
        row_d = '0;
      end else if (end_of_line_i) begin
        col_d = '0;
        row_d = row_q + CNT_W'(1);
      end else begin
        col_d = col_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

### rtl/fdwf_queue.sv
module fdwf_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = fdwf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == LAST) ? '0 : wr_q + PW'(1);
    end
    if (pop_i) begin
      rd_d = (rd_q == LAST) ? '0 : rd_q + PW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

### rtl/fdwf_back.sv
module fdwf_back #(
  parameter int unsigned WINDOW_SIZE = fdwf_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned DW          = $clog2(WINDOW_SIZE) + 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          q_empty_i,
  output logic                          q_pop_o,
  input  fdwf_pkg::fdwf_pix_t           q_pix_i,
  input  logic signed [DW-1:0]          q_dx_i,
  input  logic signed [DW-1:0]          q_dy_i,
  input  logic [fdwf_pkg::GAIN_W-1:0]   force_gain_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [fdwf_pkg::PIX_W-1:0]    diff_pixel_o,
  output logic [fdwf_pkg::CNT_W-1:0]    mirrored_column_o,
  output logic [fdwf_pkg::CNT_W-1:0]    row_index_o,
  output logic signed [fdwf_pkg::FORCE_W-1:0] force_x_o,
  output logic signed [fdwf_pkg::FORCE_W-1:0] force_y_o,
  output logic                          force_valid_o
);
  import fdwf_pkg::*;

  localparam int unsigned PW = DW + PIX_W + 1;

  localparam logic [1:0] ST_RUN  = 2'd0;
  localparam logic [1:0] ST_MULX = 2'd1;
  localparam logic [1:0] ST_MULY = 2'd2;
  localparam logic [1:0] ST_FIN  = 2'd3;

  logic [1:0]         st_q, st_d;
  logic [SUM_W-1:0]   sum_x_q, sum_x_d, sum_y_q, sum_y_d;
  logic [PROD_W-1:0]  prod_q, prod_d;
  logic [FORCE_W-1:0] fx_q, fx_d;
  fdwf_pix_t          hold_q, hold_d;
  logic               ovalid_q, ovalid_d;
  logic               can_load, load_pix, load_eof;

  logic [PIX_W-1:0]   o_diff_q;
  logic [CNT_W-1:0]   o_mcol_q, o_row_q;
  logic [FORCE_W-1:0] o_fx_q, o_fy_q;
  logic               o_fv_q;

  logic signed [PW-1:0]      px, py;
  logic [SUM_W-1:0]          mul_a;
  logic signed [PROD_W:0]    mul_p;

  assign can_load = !ovalid_q || !out_stall_i;
  assign q_pop_o  = (st_q == ST_RUN) && !q_empty_i && can_load;
  assign load_pix = q_pop_o && !q_pix_i.eof;
  assign load_eof = (st_q == ST_FIN) && can_load;

  assign px = $signed({1'b0, q_pix_i.diff}) * q_dx_i;
  assign py = $signed({1'b0, q_pix_i.diff}) * q_dy_i;

  // One multiplier serves both sums at frame end
  assign mul_a = (st_q == ST_MULX) ? sum_x_q : sum_y_q;
  assign mul_p = $signed(mul_a) * $signed({1'b0, force_gain_i});

  always_comb begin
    st_d    = st_q;
    sum_x_d = sum_x_q;
    sum_y_d = sum_y_q;
    prod_d  = prod_q;
    fx_d    = fx_q;
    hold_d  = hold_q;
    unique case (st_q)
      ST_RUN: begin
        if (q_pop_o) begin
          if (q_pix_i.in_win) begin
            sum_x_d = sum_x_q + {{(SUM_W-PW){px[PW-1]}}, px};
            sum_y_d = sum_y_q + {{(SUM_W-PW){py[PW-1]}}, py};
          end
          if (q_pix_i.eof) begin
            hold_d = q_pix_i;
            st_d   = ST_MULX;
          end
        end
      end
      ST_MULX: begin
        prod_d = mul_p[PROD_W-1:0];
        st_d   = ST_MULY;
      end
      ST_MULY: begin
        fx_d   = sat_force(prod_q);
        prod_d = mul_p[PROD_W-1:0];
        st_d   = ST_FIN;
      end
      ST_FIN: begin
        if (can_load) begin
          sum_x_d = '0;
          sum_y_d = '0;
          st_d    = ST_RUN;
        end
      end
      default: st_d = ST_RUN;
    endcase
  end

  always_comb begin
    if (load_pix || load_eof) begin
      ovalid_d = 1'b1;
    end else begin
      ovalid_d = ovalid_q && out_stall_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_RUN;
      sum_x_q  <= '0;
      sum_y_q  <= '0;
      ovalid_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      sum_x_q  <= sum_x_d;
      sum_y_q  <= sum_y_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    fx_q   <= fx_d;
    hold_q <= hold_d;
    if (load_pix) begin
      o_diff_q <= q_pix_i.diff;
      o_mcol_q <= q_pix_i.mcol;
      o_row_q  <= q_pix_i.row;
      o_fx_q   <= '0;
      o_fy_q   <= '0;
      o_fv_q   <= 1'b0;
    end else if (load_eof) begin
      o_diff_q <= hold_q.diff;
      o_mcol_q <= hold_q.mcol;
      o_row_q  <= hold_q.row;
      o_fx_q   <= fx_q;
      o_fy_q   <= sat_force(prod_q);
      o_fv_q   <= 1'b1;
    end
  end

  assign out_valid_o       = ovalid_q;
  assign diff_pixel_o      = o_diff_q;
  assign mirrored_column_o = o_mcol_q;
  assign row_index_o       = o_row_q;
  assign force_x_o         = $signed(o_fx_q);
  assign force_y_o         = $signed(o_fy_q);
  assign force_valid_o     = o_fv_q;

endmodule

### rtl/frame_diff_window_force.sv
// Channel   Handshake                 Payload
// in        in_valid_i / in_stall_o   prev_pixel_i cur_pixel_i end_of_line_i end_of_frame_i
// out       out_valid_o / out_stall_i diff_pixel_o mirrored_column_o row_index_o
//                                     force_x_o force_y_o force_valid_o
// cfg       cfg_we_i                  cfg_idx_i cfg_data_i
//
// Ordinary pixels go through the queue and the output register at one word per cycle
// while out_stall_i is low. The end-of-frame pixel holds the back end in ST_MULX, ST_MULY
// and ST_FIN: both sums pass one after the other through the single 32x16 gain multiplier.
// Reset clears the counters, the sums, the queue pointers and the output valid flag.
// in_stall_o rises only when the queue between front and back is full; the back
// end pops nothing while a stalled word waits in its output register until that is taken.
module frame_diff_window_force #(
  parameter int unsigned WINDOW_SIZE = fdwf_pkg::WINDOW_SIZE_DEF,
  parameter int unsigned QUEUE_DEPTH = fdwf_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [fdwf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [fdwf_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [fdwf_pkg::PIX_W-1:0]       prev_pixel_i,
  input  logic [fdwf_pkg::PIX_W-1:0]       cur_pixel_i,
  input  logic                             end_of_line_i,
  input  logic                             end_of_frame_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [fdwf_pkg::PIX_W-1:0]       diff_pixel_o,
  output logic [fdwf_pkg::CNT_W-1:0]       mirrored_column_o,
  output logic [fdwf_pkg::CNT_W-1:0]       row_index_o,
  output logic signed [fdwf_pkg::FORCE_W-1:0] force_x_o,
  output logic signed [fdwf_pkg::FORCE_W-1:0] force_y_o,
  output logic                             force_valid_o
);
  import fdwf_pkg::*;

  localparam int unsigned DW = $clog2(WINDOW_SIZE) + 1;
  localparam int unsigned QW = PIX_T_W + 2 * DW;

  logic [FW_W-1:0]   frame_width_q;
  logic [CNT_W-1:0]  window_left_q, window_top_q;
  logic [GAIN_W-1:0] force_gain_q;

  logic              q_push, q_pop, q_full, q_empty;
  fdwf_pix_t         f_pix, b_pix;
  logic signed [DW-1:0] f_dx, f_dy, b_dx, b_dy;
  logic [QW-1:0]     q_wdata, q_rdata;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q <= FRAME_WIDTH_RST;
      window_left_q <= WINDOW_LEFT_RST;
      window_top_q  <= WINDOW_TOP_RST;
      force_gain_q  <= FORCE_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_WIDTH: frame_width_q <= cfg_data_i[FW_W-1:0];
        CFG_WINDOW_LEFT: window_left_q <= cfg_data_i[CNT_W-1:0];
        CFG_WINDOW_TOP:  window_top_q  <= cfg_data_i[CNT_W-1:0];
        CFG_FORCE_GAIN:  force_gain_q  <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  fdwf_front #(
    .WINDOW_SIZE(WINDOW_SIZE),
    .DW         (DW)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .prev_pixel_i  (prev_pixel_i),
    .cur_pixel_i   (cur_pixel_i),
    .end_of_line_i (end_of_line_i),
    .end_of_frame_i(end_of_frame_i),
    .frame_width_i (frame_width_q),
    .window_left_i (window_left_q),
    .window_top_i  (window_top_q),
    .q_full_i      (q_full),
    .q_push_o      (q_push),
    .q_pix_o       (f_pix),
    .q_dx_o        (f_dx),
    .q_dy_o        (f_dy)
  );

  assign q_wdata = {f_pix, f_dx, f_dy};

  fdwf_queue #(
    .WIDTH(QW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_wdata),
    .full_o (q_full),
    .pop_i  (q_pop),
    .data_o (q_rdata),
    .empty_o(q_empty)
  );

  assign b_pix = q_rdata[QW-1:2*DW];
  assign b_dx  = $signed(q_rdata[2*DW-1:DW]);
  assign b_dy  = $signed(q_rdata[DW-1:0]);

  fdwf_back #(
    .WINDOW_SIZE(WINDOW_SIZE),
    .DW         (DW)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_pop_o          (q_pop),
    .q_pix_i          (b_pix),
    .q_dx_i           (b_dx),
    .q_dy_i           (b_dy),
    .force_gain_i     (force_gain_q),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .diff_pixel_o     (diff_pixel_o),
    .mirrored_column_o(mirrored_column_o),
    .row_index_o      (row_index_o),
    .force_x_o        (force_x_o),
    .force_y_o        (force_y_o),
    .force_valid_o    (force_valid_o)
  );

endmodule
